>>> rtl/core/dual_flow_leak_monitor_defines.svh
// Assertion macros for the dual flow leak monitor.
// Taken by the top level; needs nothing else.
`ifndef DUAL_FLOW_LEAK_MONITOR_DEFINES_SVH
`define DUAL_FLOW_LEAK_MONITOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DFLM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DFLM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/dflm_pkg.sv
// Shared types and constants of the dual flow leak monitor.
// No dependencies; compiled before every other file.
package dflm_pkg;

  localparam int FREQ_W  = 16;
  localparam int GAIN_W  = 16;
  localparam int FLOW_W  = 32;
  localparam int LEVEL_W = 31;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 32;
  localparam int DIV_W   = 14;

  localparam logic [DIV_W-1:0]         INTEGRAL_DIVISOR = 14'd12000;
  localparam logic signed [FLOW_W-1:0] FLOW_ZERO_LIMIT  = 32'sd39322;

  localparam logic [GAIN_W-1:0]         GAIN_RST        = 16'd12078;
  localparam logic signed [FLOW_W-1:0]  OFFSET_RST      = 32'sd0;
  localparam logic [LEVEL_W-1:0]        WARN_RST        = 31'd747110;
  localparam logic [LEVEL_W-1:0]        FAULT_RST       = 31'd499057;
  localparam logic [TIME_W-1:0]         DELAY_RST       = 32'd0;
  localparam logic [LEVEL_W-1:0]        STARTUP_RST     = 31'd0;
  localparam logic [LEVEL_W-1:0]        DEV_AVG_RST     = 31'd196608;
  localparam logic [LEVEL_W-1:0]        DEV_INT_RST     = 31'd3277;

  typedef enum logic [2:0] {
    REG_FLOW_GAIN,
    REG_FLOW_OFFSET,
    REG_WARNING_FLOW,
    REG_FAULT_FLOW,
    REG_STABILIZE_DELAY,
    REG_STARTUP_LEAK,
    REG_DEV_AVG_LIMIT,
    REG_DEV_INT_LIMIT
  } cfg_index_t;

  typedef enum logic [1:0] {
    CLASS_FAULT = 2'd0,
    CLASS_WARN  = 2'd1,
    CLASS_OK    = 2'd2
  } inflow_class_t;

  typedef enum logic [1:0] {
    ST_VALVE_OFF = 2'd0,
    ST_NO_FLOW   = 2'd1,
    ST_LEAK      = 2'd2,
    ST_OK        = 2'd3
  } station_status_t;

  typedef struct packed {
    logic [FREQ_W-1:0] inlet_freq;
    logic              inlet_alive;
    logic [FREQ_W-1:0] outlet_freq;
    logic              outlet_alive;
    logic              valve_request;
    logic              bypass_request;
    logic              reset_request;
    logic [TIME_W-1:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic signed [FLOW_W-1:0] inlet_flow;
    logic                     valve_open;
    logic                     bypassed;
    logic                     leak_seen;
    logic                     cap_lost;
    inflow_class_t            inflow_class;
    logic                     weld_permit;
    logic                     min_flow_met;
    logic                     error_latched;
    station_status_t          station_status;
  } result_t;

  typedef struct packed {
    cfg_index_t       index;
    logic [CFG_W-1:0] value;
  } cfg_write_t;

endpackage

>>> rtl/core/dflm_stream_if.sv
// Valid/ready channel carrying one item of type T.
// Used for the sample, result and configuration ports.
interface dflm_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/dflm_flow_conv.sv
// Pulse frequency to saturated Q16.16 flow: freq * gain + offset, with freq taken as zero when not alive.
// Depends on dflm_pkg.
module dflm_flow_conv import dflm_pkg::*; (
  input  logic [FREQ_W-1:0]        freq,
  input  logic                     alive,
  input  logic [GAIN_W-1:0]        gain,
  input  logic signed [FLOW_W-1:0] offset,
  output logic signed [FLOW_W-1:0] flow
);

  localparam int PROD_W = FREQ_W + GAIN_W;
  localparam int SUM_W  = FLOW_W + 2;

  logic [PROD_W-1:0]       product;
  logic signed [SUM_W-1:0] total;

  always_comb begin
    product = PROD_W'(freq & {FREQ_W{alive}}) * PROD_W'(gain);
    total   = $signed({{(SUM_W-PROD_W){1'b0}}, product}) + SUM_W'(offset);
    if (!total[SUM_W-1] && (total[SUM_W-2:FLOW_W-1] != '0)) begin
      flow = $signed({1'b0, {(FLOW_W-1){1'b1}}});
    end else if (total[SUM_W-1] && (total[SUM_W-2:FLOW_W-1] != '1)) begin
      flow = $signed({1'b1, {(FLOW_W-1){1'b0}}});
    end else begin
      flow = total[FLOW_W-1:0];
    end
  end

endmodule

>>> rtl/core/dual_flow_leak_monitor.sv
// Dual flow leak monitor, top level; depends on dflm_pkg, dflm_stream_if, dflm_flow_conv
// and dual_flow_leak_monitor_defines.svh. Each sample item gives one result item.
// The block takes one item per clock while the result side does not stall it; each item
// passes an input register, a flow stage (one 16x16 multiply per sensor) and a
// decision stage that updates the window sums and flags and loads the result register.
// The window is one memory of WINDOW_DEPTH inlet-minus-outlet differences with one read
// and one write per item; a wrap flag stands in for clearing it, so no sweep follows reset.
// Configuration writes are taken at any time (ready stays high) but belong in idle periods.
`include "dual_flow_leak_monitor_defines.svh"

module dual_flow_leak_monitor import dflm_pkg::*; #(
  parameter int WINDOW_DEPTH = 128
) (
  input logic         clk,
  input logic         rst,
  dflm_stream_if.sink   sample,
  dflm_stream_if.source result,
  dflm_stream_if.sink   cfg
);

  localparam int LOG_D = $clog2(WINDOW_DEPTH);
  localparam int PTR_W = LOG_D;
  localparam int DD_W  = FLOW_W + 1;
  localparam int SUM_W = DD_W + LOG_D;
  localparam int THR_W = LEVEL_W + DIV_W;
  localparam int AVG_W = LEVEL_W + LOG_D;
  localparam int CMP_W = ((SUM_W > THR_W) ? SUM_W : THR_W) + 1;

  localparam logic [PTR_W-1:0] PTR_LAST      = PTR_W'(WINDOW_DEPTH - 1);
  localparam logic [AVG_W-1:0] AVG_LIMIT_RST = AVG_W'(DEV_AVG_RST) * AVG_W'(WINDOW_DEPTH);
  localparam logic [THR_W-1:0] INT_LIMIT_RST =
    THR_W'(DEV_INT_RST) * THR_W'(INTEGRAL_DIVISOR);
  localparam logic [THR_W-1:0] STARTUP_LIMIT_RST =
    THR_W'(STARTUP_RST) * THR_W'(INTEGRAL_DIVISOR);

  // configuration
  logic [GAIN_W-1:0]        flow_gain;
  logic signed [FLOW_W-1:0] flow_offset;
  logic [LEVEL_W-1:0]       warning_flow;
  logic [LEVEL_W-1:0]       fault_flow;
  logic [TIME_W-1:0]        stabilize_delay_ms;
  logic [THR_W-1:0]         startup_thresh;
  logic [AVG_W-1:0]         avg_thresh;
  logic [THR_W-1:0]         int_thresh;

  // pipeline control
  logic s1_valid, s2_valid, result_valid;
  logic out_take, s2_adv, s2_free, s1_adv, accept;

  // stage registers
  sample_t                  s1_item;
  logic signed [FLOW_W-1:0] s2_flow_in, s2_flow_out;
  logic                     s2_valve_req, s2_bypass, s2_reset_req;
  logic [TIME_W-1:0]        s2_now;
  logic [PTR_W-1:0]         s2_addr;
  logic                     s2_old_ok;
  logic signed [DD_W-1:0]   mem_rd;
  result_t                  result_q;

  logic signed [FLOW_W-1:0] flow_in, flow_out;

  // window memory and running state
  logic signed [DD_W-1:0]   window [WINDOW_DEPTH];
  logic [PTR_W-1:0]         ring_pointer;
  logic                     wrapped;
  logic signed [SUM_W-1:0]  diff_sum, gap_sum;
  logic signed [DD_W-1:0]   last_dd;
  logic                     valve_state, error_flag, past_startup;
  logic                     leak_flag, caploss_flag;
  logic [TIME_W-1:0]        open_time;
  station_status_t          status_reg;

  // decision stage
  logic signed [DD_W-1:0]   old_dd, dd;
  logic signed [SUM_W-1:0]  diff_next, gap_next;
  logic                     above_warn, above_fault;
  logic                     startup_hit, avg_hit, int_hit;
  logic                     error_next, leak_next, caploss_next;
  logic                     opening, valve_next, past_next;
  logic [TIME_W-1:0]        open_next;
  station_status_t          status_next;
  inflow_class_t            class_next;
  logic                     weld_next, minflow_next;
  result_t                  result_next;

  assign out_take     = !result_valid || result.ready;
  assign s2_adv       = s2_valid && out_take;
  assign s2_free      = !s2_valid || out_take;
  assign s1_adv       = s1_valid && s2_free;
  assign sample.ready = !s1_valid || s2_free;
  assign accept       = sample.valid && sample.ready;
  assign cfg.ready    = 1'b1;
  assign result.valid = result_valid;
  assign result.data  = result_q;

  dflm_flow_conv u_conv_in (
    .freq   (s1_item.inlet_freq),
    .alive  (s1_item.inlet_alive),
    .gain   (flow_gain),
    .offset (flow_offset),
    .flow   (flow_in)
  );

  dflm_flow_conv u_conv_out (
    .freq   (s1_item.outlet_freq),
    .alive  (s1_item.outlet_alive),
    .gain   (flow_gain),
    .offset (flow_offset),
    .flow   (flow_out)
  );

  always_comb begin
    old_dd    = s2_old_ok ? mem_rd : '0;
    dd        = DD_W'(s2_flow_in) - DD_W'(s2_flow_out);
    diff_next = diff_sum + SUM_W'(dd) - SUM_W'(old_dd);
    gap_next  = gap_sum + SUM_W'(last_dd) - SUM_W'(old_dd);

    above_warn  = $signed({s2_flow_in[FLOW_W-1], s2_flow_in}) > $signed({2'b00, warning_flow});
    above_fault = $signed({s2_flow_in[FLOW_W-1], s2_flow_in}) > $signed({2'b00, fault_flow});
    priority if (above_warn || s2_bypass) begin
      class_next = CLASS_OK;
      weld_next = 1'b1;
      minflow_next = 1'b1;
    end else if (above_fault) begin
      class_next = CLASS_WARN;
      weld_next = 1'b1;
      minflow_next = 1'b0;
    end else begin
      class_next = CLASS_FAULT;
      weld_next = 1'b0;
      minflow_next = 1'b0;
    end

    startup_hit = !past_startup &&
      ($signed(CMP_W'(diff_next)) > $signed({{(CMP_W-THR_W){1'b0}}, startup_thresh}));
    avg_hit = gap_next > $signed({{(SUM_W-AVG_W){1'b0}}, avg_thresh});
    int_hit = $signed(CMP_W'(diff_next)) > $signed({{(CMP_W-THR_W){1'b0}}, int_thresh});

    error_next   = error_flag && !s2_reset_req;
    leak_next    = leak_flag;
    caploss_next = caploss_flag;
    priority if (startup_hit) begin
      caploss_next = 1'b1;
      leak_next = 1'b1;
    end else if (avg_hit && int_hit) begin
      leak_next = 1'b1;
      if (!s2_bypass) begin
        error_next = 1'b1;
      end
    end else begin
      leak_next = 1'b0;
    end

    valve_next = !error_next && s2_valve_req;
    opening    = valve_next && !valve_state;
    open_next  = opening ? s2_now : open_time;
    past_next  = past_startup && !opening;
    if (!past_next && valve_next && ((s2_now - open_next) > stabilize_delay_ms)) begin
      past_next = 1'b1;
    end

    priority if (!valve_next) begin
      status_next = ST_VALVE_OFF;
    end else if (s2_flow_in < FLOW_ZERO_LIMIT) begin
      status_next = ST_NO_FLOW;
    end else if (leak_next) begin
      status_next = ST_LEAK;
    end else if (class_next == CLASS_OK) begin
      status_next = ST_OK;
    end else begin
      status_next = status_reg;
    end

    result_next.inlet_flow     = s2_flow_in;
    result_next.valve_open     = valve_next;
    result_next.bypassed       = s2_bypass;
    result_next.leak_seen      = leak_next;
    result_next.cap_lost       = caploss_next;
    result_next.inflow_class   = class_next;
    result_next.weld_permit    = weld_next;
    result_next.min_flow_met   = minflow_next;
    result_next.error_latched  = error_next;
    result_next.station_status = status_next;
  end

  // control state, configuration and running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid           <= 1'b0;
      s2_valid           <= 1'b0;
      result_valid       <= 1'b0;
      flow_gain          <= GAIN_RST;
      flow_offset        <= OFFSET_RST;
      warning_flow       <= WARN_RST;
      fault_flow         <= FAULT_RST;
      stabilize_delay_ms <= DELAY_RST;
      startup_thresh     <= STARTUP_LIMIT_RST;
      avg_thresh         <= AVG_LIMIT_RST;
      int_thresh         <= INT_LIMIT_RST;
      ring_pointer       <= '0;
      wrapped            <= 1'b0;
      diff_sum           <= '0;
      gap_sum            <= '0;
      last_dd            <= '0;
      valve_state        <= 1'b0;
      error_flag         <= 1'b0;
      past_startup       <= 1'b0;
      open_time          <= '0;
      leak_flag          <= 1'b0;
      caploss_flag       <= 1'b0;
      status_reg         <= ST_VALVE_OFF;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
      if (s2_adv) begin
        result_valid <= 1'b1;
      end else if (result.ready) begin
        result_valid <= 1'b0;
      end

      if (cfg.valid) begin
        unique case (cfg.data.index)
          REG_FLOW_GAIN:       flow_gain <= cfg.data.value[GAIN_W-1:0];
          REG_FLOW_OFFSET:     flow_offset <= $signed(cfg.data.value);
          REG_WARNING_FLOW:    warning_flow <= cfg.data.value[LEVEL_W-1:0];
          REG_FAULT_FLOW:      fault_flow <= cfg.data.value[LEVEL_W-1:0];
          REG_STABILIZE_DELAY: stabilize_delay_ms <= cfg.data.value;
          REG_STARTUP_LEAK: begin
            startup_thresh <= THR_W'(cfg.data.value[LEVEL_W-1:0]) * THR_W'(INTEGRAL_DIVISOR);
          end
          REG_DEV_AVG_LIMIT: begin
            avg_thresh <= AVG_W'(cfg.data.value[LEVEL_W-1:0]) * AVG_W'(WINDOW_DEPTH);
          end
          REG_DEV_INT_LIMIT: begin
            int_thresh <= THR_W'(cfg.data.value[LEVEL_W-1:0]) * THR_W'(INTEGRAL_DIVISOR);
          end
        endcase
      end

      // advance the ring as each item leaves the flow stage
      if (s1_adv) begin
        ring_pointer <= (ring_pointer == PTR_LAST) ? '0 : ring_pointer + 1'b1;
        if (ring_pointer == PTR_LAST) begin
          wrapped <= 1'b1;
        end
      end

      if (s2_adv) begin
        diff_sum     <= diff_next;
        gap_sum      <= gap_next;
        last_dd      <= dd;
        valve_state  <= valve_next;
        error_flag   <= error_next;
        past_startup <= past_next;
        open_time    <= open_next;
        leak_flag    <= leak_next;
        caploss_flag <= caploss_next;
        status_reg   <= status_next;
      end
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= sample.data;
    end
    if (s1_adv) begin
      s2_flow_in   <= flow_in;
      s2_flow_out  <= flow_out;
      s2_valve_req <= s1_item.valve_request;
      s2_bypass    <= s1_item.bypass_request;
      s2_reset_req <= s1_item.reset_request;
      s2_now       <= s1_item.now_ms;
      s2_addr      <= ring_pointer;
      s2_old_ok    <= wrapped;
    end
    if (s2_adv) begin
      result_q <= result_next;
    end
  end

  // window memory: read the oldest entry ahead, write the newest difference
  always_ff @(posedge clk) begin
    if (s2_adv) begin
      window[s2_addr] <= dd;
    end
    if (s1_adv) begin
      mem_rd <= window[ring_pointer];
    end
  end

  `DFLM_ASSERT_NOW(a_valve_gated, clk, rst, valve_state, !error_flag, "valve open with error latched")
  `DFLM_ASSERT_NEXT(a_caploss_sticky, clk, rst, caploss_flag, caploss_flag, "cap-loss flag dropped")
  `DFLM_ASSERT_NOW(a_ring_range, clk, rst, 1'b1, ring_pointer <= PTR_LAST, "ring pointer out of range")

endmodule
